[sv/modular_exponentiation_defines.svh]
// ----------------------------------------------------------------------------
// modular exponentiation assertion macros
// shared concurrent check helpers for the exponentiation block
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// condition holds on every clock outside reset
`define MEXP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MEXP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[sv/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// widths, tags and the word type that moves along the multiplier chain
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int MOD_BITS = 32;
    localparam int DATA_W   = 32;

    // configuration register indexes
    localparam logic CFG_EXPONENT = 1'b0;
    localparam logic CFG_MODULUS  = 1'b1;

    typedef enum logic {
        TAG_SQ  = 1'b0,
        TAG_ACC = 1'b1
    } t_tag;

    // one partial product in flight
    typedef struct packed {
        logic                valid;
        t_tag                tag;
        logic [MOD_BITS-1:0] r;
        logic [MOD_BITS-1:0] a;
        logic [MOD_BITS-1:0] b;
    } t_op;

endpackage

[sv/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation
// rsa power of each word modulo a configured modulus
// ----------------------------------------------------------------------------
// One word at a time: an accepted base is reduced, then raised to the exponent
// by right-to-left square-and-multiply. Every modular multiply runs through a
// chain of MOD_BITS cells, one multiplier bit per cell; the multiply and the
// square of one exponent bit enter back to back. A word takes the reduction
// plus one step per exponent bit up to the highest set bit; a zero exponent
// gives 1 without passing through the chain. The result sits in an output
// register, so the next word is taken while it waits. A modulus of zero acts
// as 2^MOD_BITS. Write configuration only while idle.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_defines.svh"

module modular_exponentiation (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [mexp_pkg::DATA_W-1:0] i_cfg_data,
    // input words
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [mexp_pkg::DATA_W-1:0] i_base,
    input  logic                        i_last_in,
    // result words
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mexp_pkg::DATA_W-1:0] o_power,
    output logic                        o_last_out
);

    localparam int W = mexp_pkg::MOD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_STEP2,
        S_WAIT,
        S_OUT
    } t_state;

    // configuration registers
    logic [mexp_pkg::DATA_W-1:0] r_exp;
    logic [mexp_pkg::DATA_W-1:0] r_mod;

    // sequencer state
    t_state                      r_state;
    logic [mexp_pkg::DATA_W-1:0] r_e;
    logic [W-1:0]                r_acc;
    logic [W-1:0]                r_sq;
    logic [1:0]                  r_pend;
    logic                        r_last;

    // output register
    logic                        r_out_valid;
    logic [mexp_pkg::DATA_W-1:0] r_power;
    logic                        r_last_out;

    logic [W:0]                  mz;       // modulus, zero means 2^W
    mexp_pkg::t_op               issue;
    mexp_pkg::t_op               links [0:W];
    mexp_pkg::t_op               ret;
    logic                        accept;
    logic                        out_free;

    assign mz       = {(r_mod[W-1:0] == '0), r_mod[W-1:0]};
    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign ret      = links[W];

    // word entering the chain this cycle
    always_comb begin
        issue       = '0;
        issue.tag   = mexp_pkg::TAG_SQ;
        unique case (r_state)
            S_IDLE: begin
                // base reduction: base * 1 mod m
                if (accept && (r_exp != '0)) begin
                    issue.valid = 1'b1;
                    issue.a     = i_base[W-1:0];
                    issue.b     = W'(1);
                end
            end
            S_STEP: begin
                if (r_e[0]) begin
                    issue.valid = 1'b1;
                    issue.tag   = mexp_pkg::TAG_ACC;
                    issue.a     = r_acc;
                    issue.b     = r_sq;
                end
            end
            S_STEP2: begin
                if (r_e[mexp_pkg::DATA_W-1:1] != '0) begin
                    issue.valid = 1'b1;
                    issue.a     = r_sq;
                    issue.b     = r_sq;
                end
            end
            default: begin
                issue.valid = 1'b0;
            end
        endcase
    end

    assign links[0] = issue;

    // row of multiplier cells, one operand bit each
    genvar gi;
    generate
        for (gi = 0; gi < W; gi++) begin : g_cell
            mexp_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_mz    (mz),
                .i_op    (links[gi]),
                .o_op    (links[gi+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        // configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mexp_pkg::CFG_EXPONENT: r_exp <= i_cfg_data;
                mexp_pkg::CFG_MODULUS:  r_mod <= i_cfg_data;
                default: r_exp <= r_exp;
            endcase
        end

        // finished products land in their register
        if (ret.valid) begin
            if (ret.tag == mexp_pkg::TAG_ACC) begin
                r_acc <= ret.r;
            end else begin
                r_sq <= ret.r;
            end
        end

        r_pend <= r_pend + 2'(issue.valid) - 2'(ret.valid);

        if (o_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_last <= i_last_in;
                    r_e    <= r_exp;
                    if (r_exp == '0) begin
                        r_acc   <= W'(1);
                        r_state <= S_OUT;
                    end else begin
                        // reduce(1, m): zero only for a modulus of one
                        r_acc   <= (mz == (W+1)'(1)) ? '0 : W'(1);
                        r_state <= S_WAIT;
                    end
                end
            end
            S_STEP: begin
                r_state <= S_STEP2;
            end
            S_STEP2: begin
                r_e     <= r_e >> 1;
                r_state <= S_WAIT;
            end
            S_WAIT: begin
                // all products of this bit returned
                if ((r_pend == 2'd1 && ret.valid) || r_pend == 2'd0) begin
                    r_state <= (r_e == '0) ? S_OUT : S_STEP;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                    r_power     <= mexp_pkg::DATA_W'(r_acc);
                    r_last_out  <= r_last;
                    r_state     <= S_IDLE;
                end
            end
            default: begin
                r_state <= S_IDLE;
            end
        endcase

        if (!i_rst_n) begin
            r_exp       <= mexp_pkg::DATA_W'(17);
            r_mod       <= mexp_pkg::DATA_W'(143);
            r_state     <= S_IDLE;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_power     = r_power;
    assign o_last_out  = r_last_out;

    // no more than a multiply and a square in flight
    `MEXP_ASSERT_ALWAYS(a_pend_max, i_clk, i_rst_n, r_pend != 2'd3, "too many products in flight")
    // chain drains before a word is finished
    `MEXP_ASSERT_ALWAYS(a_idle_empty, i_clk, i_rst_n,
        (r_state != S_IDLE && r_state != S_OUT) || r_pend == 2'd0, "chain busy while idle")
    // a product leaves the chain only if one was issued
    `MEXP_ASSERT_ALWAYS(a_ret_pend, i_clk, i_rst_n, !ret.valid || r_pend != 2'd0,
        "unexpected product")
    // a word handed to the output register shows up there
    `MEXP_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, r_state == S_OUT && out_free,
        o_out_valid && r_state == S_IDLE, "result not loaded")

endmodule

[sv/mexp_cell.sv]
// ----------------------------------------------------------------------------
// mexp_cell
// one horner step of an interleaved modular multiply: r = 2r + a_msb*b mod m
// ----------------------------------------------------------------------------
module mexp_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [mexp_pkg::MOD_BITS:0]  i_mz,
    input  mexp_pkg::t_op                i_op,
    output mexp_pkg::t_op                o_op
);

    localparam int W = mexp_pkg::MOD_BITS;

    logic [W+1:0] s0;
    logic [W+1:0] s1;
    logic [W+1:0] s2;
    logic [W+1:0] mext;
    mexp_pkg::t_op r_op;
    mexp_pkg::t_op n_op;

    always_comb begin
        mext = {1'b0, i_mz};
        s0   = {1'b0, i_op.r, 1'b0} + (i_op.a[W-1] ? {2'b00, i_op.b} : '0);
        s1   = (s0 >= mext) ? s0 - mext : s0;
        s2   = (s1 >= mext) ? s1 - mext : s1;
        n_op       = i_op;
        n_op.r     = s2[W-1:0];
        n_op.a     = {i_op.a[W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        if (!i_rst_n) begin
            r_op.valid <= 1'b0;
        end
    end

    assign o_op = r_op;

endmodule
